>>> design/ptib_pkg.sv
// shared types and constants of the temporal bandpass amplifier
package ptib_pkg;

	localparam int ENTRY_COUNT = 524288;
	localparam int ADDR_W      = $clog2(ENTRY_COUNT);
	localparam int MAX_LEVELS  = 16;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam int COEF_W   = 18;
	localparam int SAMPLE_W = 16;
	localparam int STATE_W  = 24;
	localparam int GAIN_W   = 16;
	localparam int EADDR_W  = 19;
	localparam int LEVEL_W  = 4;
	localparam int LCOUNT_W = 5;

	localparam logic [2:0] REG_HIGH_A0     = 3'd0;
	localparam logic [2:0] REG_HIGH_A1     = 3'd1;
	localparam logic [2:0] REG_HIGH_B1     = 3'd2;
	localparam logic [2:0] REG_LOW_A0      = 3'd3;
	localparam logic [2:0] REG_LOW_A1      = 3'd4;
	localparam logic [2:0] REG_LOW_B1      = 3'd5;
	localparam logic [2:0] REG_LEVEL_COUNT = 3'd6;

	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] b1;
	} coef_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] prev;
		logic signed [STATE_W-1:0]  upper;
		logic signed [STATE_W-1:0]  lower;
	} entry_t;

endpackage

>>> design/ptib_lowpass.sv
// first-order lowpass: 64*(a0*x+a1*prev) - b1*state, rounded >>16, saturated
module ptib_lowpass (
	input  ptib_pkg::coef_t                        coef,
	input  logic signed [ptib_pkg::SAMPLE_W-1:0]   x,
	input  logic signed [ptib_pkg::SAMPLE_W-1:0]   prev,
	input  logic signed [ptib_pkg::STATE_W-1:0]    state,
	output logic signed [ptib_pkg::STATE_W-1:0]    state_next
);
	import ptib_pkg::*;

	localparam int PX_W  = COEF_W + SAMPLE_W;
	localparam int PS_W  = COEF_W + STATE_W;
	localparam int ACC_W = PS_W + 2;
	localparam int Q_W   = ACC_W - 16;

	logic signed [PX_W-1:0]  p_x;
	logic signed [PX_W-1:0]  p_prev;
	logic signed [PX_W:0]    p_sum;
	logic signed [PS_W-1:0]  p_state;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_r;
	logic signed [Q_W-1:0]   q;

	localparam logic signed [Q_W-1:0] SMAX = Q_W'((1 <<< (STATE_W - 1)) - 1);
	localparam logic signed [Q_W-1:0] SMIN = -Q_W'(1 <<< (STATE_W - 1));

	assign p_x     = PX_W'(coef.a0) * PX_W'(x);
	assign p_prev  = PX_W'(coef.a1) * PX_W'(prev);
	assign p_sum   = (PX_W + 1)'(p_x) + (PX_W + 1)'(p_prev);
	assign p_state = PS_W'(coef.b1) * PS_W'(state);
	assign acc     = (ACC_W'(p_sum) <<< 6) - ACC_W'(p_state);
	assign acc_r   = acc + ACC_W'(32768);
	assign q       = acc_r[ACC_W-1:16];

	always_comb begin
		priority if (q > SMAX) begin
			state_next = SMAX[STATE_W-1:0];
		end else if (q < SMIN) begin
			state_next = SMIN[STATE_W-1:0];
		end else begin
			state_next = q[STATE_W-1:0];
		end
	end

endmodule

>>> design/ptib_out_fifo.sv
// result queue between the datapath and the output channel
module ptib_out_fifo (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  logic [ptib_pkg::EADDR_W-1:0]          push_addr,
	input  logic signed [ptib_pkg::SAMPLE_W-1:0]  push_value,
	input  logic                                  pop,
	output logic                                  valid,
	output logic [ptib_pkg::EADDR_W-1:0]          head_addr,
	output logic signed [ptib_pkg::SAMPLE_W-1:0]  head_value,
	output logic [ptib_pkg::FIFO_CNT_W-1:0]       count
);
	import ptib_pkg::*;

	logic [EADDR_W-1:0]         addr_q  [FIFO_DEPTH];
	logic signed [SAMPLE_W-1:0] value_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]      wr_ptr_q;
	logic [FIFO_PTR_W-1:0]      rd_ptr_q;
	logic [FIFO_CNT_W-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			addr_q[wr_ptr_q]  <= push_addr;
			value_q[wr_ptr_q] <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= FIFO_PTR_W'((32'(wr_ptr_q) + 1) % FIFO_DEPTH);
			end
			if (pop) begin
				rd_ptr_q <= FIFO_PTR_W'((32'(rd_ptr_q) + 1) % FIFO_DEPTH);
			end
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	assign valid      = (count_q != '0);
	assign head_addr  = addr_q[rd_ptr_q];
	assign head_value = value_q[rd_ptr_q];
	assign count      = count_q;

endmodule

>>> design/pixel_temporal_iir_bandpass_amplifier_unit.sv
// temporal iir bandpass amplifier: per-entry state memory, filters and gain stage
//
// input channel: one pyramid coefficient per item (entry_addr, level, sample,
// band_gain, first_frame); an item is taken when in_valid is high and in_stall low.
// output channel: one result per item (addr_out, band_value), in input order,
// taken when out_valid is high and out_stall low.
// configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register, cfg_data carries the value; cfg_ready is always high.
// throughput: one item per cycle while in_stall is low; the per-entry state memory is read and
// written once per item and back-to-back hits on one entry are forwarded.
// pipeline: memory read, filter update, gain multiply, then round and saturate
// into the result queue, in that order, before out_valid rises.
// when out_stall is held the eight-deep result queue fills and in_stall rises
// so that no item in flight is lost.
// reset clears the pipeline, the result queue and the registers (coefficients
// zero, level_count eight); the state memory is not cleared, so every entry
// must see a first_frame item before it is used.
module pixel_temporal_iir_bandpass_amplifier_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [ptib_pkg::EADDR_W-1:0]          entry_addr,
	input  logic [ptib_pkg::LEVEL_W-1:0]          level,
	input  logic signed [ptib_pkg::SAMPLE_W-1:0]  sample,
	input  logic [ptib_pkg::GAIN_W-1:0]           band_gain,
	input  logic                                  first_frame,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [ptib_pkg::EADDR_W-1:0]          addr_out,
	output logic signed [ptib_pkg::SAMPLE_W-1:0]  band_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [2:0]                            cfg_index,
	input  logic [ptib_pkg::COEF_W-1:0]           cfg_data
);
	import ptib_pkg::*;

	localparam int DIFF_W = STATE_W + 1;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;
	localparam int OQ_W   = PROD_W - 14;
	localparam logic signed [OQ_W-1:0] OMAX = OQ_W'((1 <<< (SAMPLE_W - 1)) - 1);
	localparam logic signed [OQ_W-1:0] OMIN = -OQ_W'(1 <<< (SAMPLE_W - 1));

	// configuration registers
	coef_t                high_q;
	coef_t                low_q;
	logic [LCOUNT_W-1:0]  level_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q        <= '0;
			low_q         <= '0;
			level_count_q <= LCOUNT_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HIGH_A0:     high_q.a0     <= cfg_data;
				REG_HIGH_A1:     high_q.a1     <= cfg_data;
				REG_HIGH_B1:     high_q.b1     <= cfg_data;
				REG_LOW_A0:      low_q.a0      <= cfg_data;
				REG_LOW_A1:      low_q.a1      <= cfg_data;
				REG_LOW_B1:      low_q.b1      <= cfg_data;
				REG_LEVEL_COUNT: level_count_q <= cfg_data[LCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	logic                   in_acc;
	logic [ADDR_W-1:0]      in_idx;
	logic [FIFO_CNT_W-1:0]  fifo_count;
	logic [FIFO_CNT_W-1:0]  in_flight;

	// state memory
	entry_t mem [ENTRY_COUNT];
	entry_t rd_q;

	// stage 1: filter update
	logic                       v_s1;
	logic [EADDR_W-1:0]         addr_s1;
	logic [LEVEL_W-1:0]         level_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [GAIN_W-1:0]          gain_s1;
	logic                       first_s1;

	// stage 2: write back and gain multiply
	logic                       v_s2;
	logic [EADDR_W-1:0]         addr_s2;
	entry_t                     ent_s2;
	logic [GAIN_W-1:0]          gain_s2;
	logic                       zero_s2;

	// last write, for hits read in the same cycle it landed
	logic                       wb_v_q;
	logic [ADDR_W-1:0]          wb_idx_q;
	entry_t                     wb_ent_q;

	// stage 3: round and saturate
	logic                       v_s3;
	logic [EADDR_W-1:0]         addr_s3;
	logic signed [PROD_W-1:0]   prod_s3;
	logic                       zero_s3;

	assign in_idx    = entry_addr[ADDR_W-1:0];
	assign in_flight = FIFO_CNT_W'(v_s1) + FIFO_CNT_W'(v_s2) + FIFO_CNT_W'(v_s3);
	assign in_stall  = (fifo_count + in_flight) >= FIFO_CNT_W'(FIFO_DEPTH);
	assign in_acc    = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= mem[in_idx];
		end
		if (v_s2) begin
			mem[addr_s2[ADDR_W-1:0]] <= ent_s2;
		end
	end

	entry_t                      old_s1;
	logic signed [STATE_W-1:0]   up_next;
	logic signed [STATE_W-1:0]   lo_next;
	logic signed [STATE_W-1:0]   load_state;
	logic [LCOUNT_W-1:0]         lc_eff;
	logic                        pass_s1;

	always_comb begin
		priority if (v_s2 && (addr_s2[ADDR_W-1:0] == addr_s1[ADDR_W-1:0])) begin
			old_s1 = ent_s2;
		end else if (wb_v_q && (wb_idx_q == addr_s1[ADDR_W-1:0])) begin
			old_s1 = wb_ent_q;
		end else begin
			old_s1 = rd_q;
		end
	end

	ptib_lowpass u_upper (
		.coef       (high_q),
		.x          (x_s1),
		.prev       (old_s1.prev),
		.state      (old_s1.upper),
		.state_next (up_next)
	);

	ptib_lowpass u_lower (
		.coef       (low_q),
		.x          (x_s1),
		.prev       (old_s1.prev),
		.state      (old_s1.lower),
		.state_next (lo_next)
	);

	assign load_state = STATE_W'(x_s1) <<< 6;
	assign lc_eff     = (level_count_q > LCOUNT_W'(MAX_LEVELS)) ?
		LCOUNT_W'(MAX_LEVELS) : level_count_q;
	assign pass_s1    = (level_s1 != '0) &&
		((LCOUNT_W'(level_s1) + LCOUNT_W'(1)) < lc_eff);

	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [OQ_W-1:0]   oq_s3;
	logic signed [PROD_W-1:0] prod_r_s3;
	logic signed [SAMPLE_W-1:0] result_s3;

	assign diff_s2 = DIFF_W'(ent_s2.upper) - DIFF_W'(ent_s2.lower);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			wb_v_q <= 1'b0;
		end else begin
			v_s1   <= in_acc;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			wb_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1  <= entry_addr;
			level_s1 <= level;
			x_s1     <= sample;
			gain_s1  <= band_gain;
			first_s1 <= first_frame;
		end
		if (v_s1) begin
			addr_s2     <= addr_s1;
			ent_s2.prev <= x_s1;
			gain_s2     <= gain_s1;
			zero_s2     <= first_s1 || !pass_s1;
			if (first_s1) begin
				ent_s2.upper <= load_state;
				ent_s2.lower <= load_state;
			end else begin
				ent_s2.upper <= up_next;
				ent_s2.lower <= lo_next;
			end
		end
		if (v_s2) begin
			wb_idx_q <= addr_s2[ADDR_W-1:0];
			wb_ent_q <= ent_s2;
			addr_s3  <= addr_s2;
			zero_s3  <= zero_s2;
			prod_s3  <= PROD_W'(diff_s2) * PROD_W'($signed({1'b0, gain_s2}));
		end
	end

	assign prod_r_s3 = prod_s3 + PROD_W'(8192);
	assign oq_s3     = prod_r_s3[PROD_W-1:14];

	always_comb begin
		priority if (zero_s3) begin
			result_s3 = '0;
		end else if (oq_s3 > OMAX) begin
			result_s3 = OMAX[SAMPLE_W-1:0];
		end else if (oq_s3 < OMIN) begin
			result_s3 = OMIN[SAMPLE_W-1:0];
		end else begin
			result_s3 = oq_s3[SAMPLE_W-1:0];
		end
	end

	ptib_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (v_s3),
		.push_addr  (addr_s3),
		.push_value (result_s3),
		.pop        (out_valid && !out_stall),
		.valid      (out_valid),
		.head_addr  (addr_out),
		.head_value (band_value),
		.count      (fifo_count)
	);

`ifndef SYNTH
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fifo_count) + 32'(in_flight)) <= FIFO_DEPTH)
		else $error("result queue credit exceeded");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (32'(fifo_count) < FIFO_DEPTH || (out_valid && !out_stall)))
		else $error("result pushed into full queue");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("accepted item did not enter the pipeline");

	a_zero_first: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && zero_s3) |-> (result_s3 == '0))
		else $error("suppressed level gave a nonzero result");
`endif

endmodule

>>> test/testbench.sv
// testbench of the temporal iir bandpass amplifier: random and directed items against a predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ptib_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic [COEF_W-1:0] COEF_MAX = 18'h1FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN = 18'h20000;
	localparam longint STATE_MAX = 8388607;
	localparam longint STATE_MIN = -8388608;

	typedef struct {
		logic [EADDR_W-1:0]         addr;
		logic [LEVEL_W-1:0]         level;
		logic signed [SAMPLE_W-1:0] sample;
		logic [GAIN_W-1:0]          gain;
		logic                       first;
	} coeff_item_t;

	typedef struct {
		logic [EADDR_W-1:0]         addr;
		logic signed [SAMPLE_W-1:0] value;
	} band_t;

	class band_value_predictor;
		logic signed [COEF_W-1:0]   coef [6];
		logic [LCOUNT_W-1:0]        level_count;
		logic signed [SAMPLE_W-1:0] prev_sample [int];
		logic signed [STATE_W-1:0]  upper_state [int];
		logic signed [STATE_W-1:0]  lower_state [int];
		band_t                      expected_bands [$];
		int                         mismatches;

		function new();
			foreach (coef[i]) coef[i] = '0;
			level_count = 5'd8;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [COEF_W-1:0] data);
			case (idx)
				REG_LEVEL_COUNT: level_count = data[LCOUNT_W-1:0];
				REG_UNUSED: ;
				default: coef[idx] = data;
			endcase
		endfunction

		function logic signed [STATE_W-1:0] lowpass(int base, logic signed [SAMPLE_W-1:0] x,
				logic signed [SAMPLE_W-1:0] prev, logic signed [STATE_W-1:0] state);
			longint acc;
			acc = (longint'(coef[base]) * x + longint'(coef[base+1]) * prev) * 64
				- longint'(coef[base+2]) * state;
			acc = (acc + 64'sd32768) >>> 16;
			if (acc > STATE_MAX) acc = STATE_MAX;
			if (acc < STATE_MIN) acc = STATE_MIN;
			return STATE_W'(acc);
		endfunction

		function void note_coefficient(coeff_item_t it);
			int                        e;
			int                        lc;
			logic signed [STATE_W-1:0] up;
			logic signed [STATE_W-1:0] lo;
			longint                    scaled;
			band_t                     exp_band;
			e = int'(it.addr);
			exp_band.addr = it.addr;
			exp_band.value = '0;
			if (it.first) begin
				prev_sample[e] = it.sample;
				upper_state[e] = STATE_W'(longint'(it.sample) * 64);
				lower_state[e] = STATE_W'(longint'(it.sample) * 64);
			end else begin
				up = lowpass(int'(REG_HIGH_A0), it.sample, prev_sample[e], upper_state[e]);
				lo = lowpass(int'(REG_LOW_A0), it.sample, prev_sample[e], lower_state[e]);
				upper_state[e] = up;
				lower_state[e] = lo;
				prev_sample[e] = it.sample;
				lc = (level_count > MAX_LEVELS) ? MAX_LEVELS : int'(level_count);
				if (it.level != 0 && int'(it.level) < lc - 1) begin
					scaled = ((longint'(up) - longint'(lo)) * longint'(it.gain) + 64'sd8192) >>> 14;
					if (scaled > 32767) scaled = 32767;
					if (scaled < -32768) scaled = -32768;
					exp_band.value = SAMPLE_W'(scaled);
				end
			end
			expected_bands.push_back(exp_band);
		endfunction

		function void check_band(logic [EADDR_W-1:0] addr, logic signed [SAMPLE_W-1:0] value);
			band_t exp_band;
			if (expected_bands.size() == 0) begin
				$error("unexpected item: addr_out %0d band_value %0d", addr, value);
				mismatches++;
				return;
			end
			exp_band = expected_bands.pop_front();
			if (addr !== exp_band.addr) begin
				$error("addr_out: expected %0d, actual %0d", exp_band.addr, addr);
				mismatches++;
			end
			if (value !== exp_band.value) begin
				$error("band_value: expected %0d, actual %0d", exp_band.value, value);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_bands.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [EADDR_W-1:0]         entry_addr;
	logic [LEVEL_W-1:0]         level;
	logic signed [SAMPLE_W-1:0] sample;
	logic [GAIN_W-1:0]          band_gain;
	logic                       first_frame;
	logic                       out_valid;
	logic                       out_stall;
	logic [EADDR_W-1:0]         addr_out;
	logic signed [SAMPLE_W-1:0] band_value;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [2:0]                 cfg_index;
	logic [COEF_W-1:0]          cfg_data;

	band_value_predictor predictor = new();
	int unsigned         entry_pool [$];
	bit                  loaded [int];
	int unsigned         last_addr;
	int                  quiet_left;

	pixel_temporal_iir_bandpass_amplifier_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.entry_addr(entry_addr),
		.level(level),
		.sample(sample),
		.band_gain(band_gain),
		.first_frame(first_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.addr_out(addr_out),
		.band_value(band_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) predictor.check_band(addr_out, band_value);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		predictor.write_reg(idx, data);
	endtask

	task automatic close_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_filter(input logic [COEF_W-1:0] h0, input logic [COEF_W-1:0] h1,
			input logic [COEF_W-1:0] hb, input logic [COEF_W-1:0] l0,
			input logic [COEF_W-1:0] l1, input logic [COEF_W-1:0] lb,
			input logic [COEF_W-1:0] lc);
		write_reg(REG_HIGH_A0, h0);
		write_reg(REG_HIGH_A1, h1);
		write_reg(REG_HIGH_B1, hb);
		write_reg(REG_LOW_A0, l0);
		write_reg(REG_LOW_A1, l1);
		write_reg(REG_LOW_B1, lb);
		write_reg(REG_LEVEL_COUNT, lc);
		close_writes();
	endtask

	function automatic logic [COEF_W-1:0] random_coef();
		if ($urandom_range(0, 1) == 0) return COEF_W'($urandom);
		return COEF_W'(int'($urandom_range(0, 80000)) - 40000);
	endfunction

	function automatic logic [COEF_W-1:0] random_level_count();
		int lc;
		lc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(3, 16);
		return {13'($urandom), 5'(lc)};
	endfunction

	function automatic coeff_item_t make_item(int unsigned addr, int lvl, int smp, int gain,
			bit first);
		coeff_item_t it;
		it.addr = EADDR_W'(addr);
		it.level = LEVEL_W'(lvl);
		it.sample = SAMPLE_W'(smp);
		it.gain = GAIN_W'(gain);
		it.first = first;
		return it;
	endfunction

	function automatic coeff_item_t random_item();
		coeff_item_t it;
		int          pick;
		int unsigned a;
		pick = $urandom_range(0, 99);
		if (pick < 20 && loaded.exists(int'(last_addr))) a = last_addr;
		else if (pick < 88) a = entry_pool[$urandom_range(0, entry_pool.size() - 1)];
		else a = $urandom_range(0, ENTRY_COUNT - 1);
		last_addr = a;
		it.addr = EADDR_W'(a);
		it.first = !loaded.exists(int'(a)) || ($urandom_range(0, 99) < 3);
		it.level = LEVEL_W'($urandom_range(0, 15));
		pick = $urandom_range(0, 9);
		if (pick == 0) it.sample = 16'sh7FFF;
		else if (pick == 1) it.sample = 16'sh8000;
		else it.sample = SAMPLE_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10) it.gain = '0;
		else if (pick < 20) it.gain = 16'hFFFF;
		else if (pick < 65) it.gain = GAIN_W'($urandom_range(0, 1024));
		else it.gain = GAIN_W'($urandom);
		return it;
	endfunction

	function automatic int sender_gap();
		int pick;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			quiet_left = $urandom_range(60, 150);
			return 0;
		end
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic drive_item(input coeff_item_t it);
		in_valid <= 1'b1;
		entry_addr <= it.addr;
		level <= it.level;
		sample <= it.sample;
		band_gain <= it.gain;
		first_frame <= it.first;
		do @(posedge clk); while (in_stall);
		predictor.note_coefficient(it);
		if (it.first) loaded[int'(it.addr)] = 1'b1;
	endtask

	task automatic wait_drained();
		while (predictor.pending() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		int gap;
		for (int i = 0; i < count; i++) begin
			drive_item(random_item());
			if (i == count - 1) begin
			end else if (i == count / 2) begin
				in_valid <= 1'b0;
				wait_drained();
			end else begin
				gap = sender_gap();
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic run_directed();
		coeff_item_t steps [$];
		steps.push_back(make_item(0, 1, 32767, 65535, 1'b1));
		steps.push_back(make_item(ENTRY_COUNT - 1, 15, -32768, 0, 1'b1));
		steps.push_back(make_item(0, 1, -32768, 65535, 1'b0));
		steps.push_back(make_item(ENTRY_COUNT - 1, 2, 32767, 65535, 1'b0));
		steps.push_back(make_item(0, 14, -32768, 65535, 1'b0));
		steps.push_back(make_item(0, 15, 32767, 65535, 1'b0));
		steps.push_back(make_item(0, 0, 32767, 65535, 1'b0));
		steps.push_back(make_item(ENTRY_COUNT - 1, 7, -32768, 0, 1'b0));
		steps.push_back(make_item(ENTRY_COUNT - 1, 7, 0, 256, 1'b0));
		steps.push_back(make_item(0, 3, -32768, 65535, 1'b1));
		steps.push_back(make_item(0, 3, 32767, 65535, 1'b0));
		steps.push_back(make_item(0, 3, 32767, 65535, 1'b0));
		steps.push_back(make_item(0, 3, 32767, 1, 1'b0));
		steps.push_back(make_item(12345, 5, 100, 512, 1'b1));
		steps.push_back(make_item(12345, 5, -100, 512, 1'b0));
		steps.push_back(make_item(12345, 8, 0, 65535, 1'b0));
		foreach (steps[i]) drive_item(steps[i]);
		in_valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		int stall_len;
		int run_len;
		int pick;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 40) stall_len = 0;
			else if (pick < 80) stall_len = $urandom_range(1, 2);
			else if (pick < 97) stall_len = $urandom_range(3, 10);
			else stall_len = $urandom_range(20, 50);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			run_len = ($urandom_range(0, 99) < 3) ? $urandom_range(100, 300) : $urandom_range(1, 6);
			repeat (run_len) @(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		entry_addr = '0;
		level = '0;
		sample = '0;
		band_gain = '0;
		first_frame = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_HIGH_A0;
		cfg_data = '0;
		quiet_left = 0;
		last_addr = 0;
		entry_pool.push_back(0);
		entry_pool.push_back(ENTRY_COUNT - 1);
		repeat (38) entry_pool.push_back($urandom_range(0, ENTRY_COUNT - 1));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients, default level count
		run_random(40);

		program_filter(COEF_W'(13107), COEF_W'(13107), COEF_W'(-39322),
			COEF_W'(3277), COEF_W'(3277), COEF_W'(-58982), COEF_W'(16));
		run_directed();
		run_random(320);

		program_filter(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, 18'h3FFFF);
		run_random(320);

		program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX, COEF_W'(3));
		run_random(180);

		program_filter(random_coef(), random_coef(), random_coef(), random_coef(),
			random_coef(), random_coef(), COEF_W'(0));
		write_reg(REG_UNUSED, COEF_W'($urandom));
		close_writes();
		run_random(150);

		write_reg(REG_LEVEL_COUNT, COEF_W'(1));
		close_writes();
		run_random(150);

		repeat (3) begin
			program_filter(random_coef(), random_coef(), random_coef(), random_coef(),
				random_coef(), random_coef(), random_level_count());
			run_random(160);
		end

		repeat (10) @(posedge clk);
		if (predictor.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
